>>> rtl/core/tcp_pkg.sv
package tcp_pkg;

	// Per-item control that travels beside the data from the product stage to the output.
	typedef struct packed {
		logic       vld;       // stage holds an item
		logic       ok;        // determinant positive
		logic       enclosed;  // both barycentric numerators in range
		logic [2:0] neg;       // sign of each numerator, x y z
	} tcp_flags_t;

endpackage

>>> rtl/core/triangle_closest_point_to_origin_top.sv
// Closest point to the origin of a triangle's plane, fixed point, fully pipelined.
//
// Input channel: the nine vertex coordinates are taken in a transfer at a rising
// edge with start high and busy low. busy stays low: the pipeline takes a new
// triangle in every cycle, so a stream of triangles runs at one item per clock.
// Output channel: one result per transfer. done is high for exactly one cycle and
// the result ports hold valid_res, near_x/y/z, dist_sq and inside_res in that
// cycle only; the receiver cannot stall, so nothing is ever held back.
// The depth is set by the restoring divider: one quotient bit per stage,
// COORD_BITS + FRAC_EXTRA stages, three lanes (x, y, z) side by side sharing
// the divisor.
// Stages: s1 edge vectors, s2 dot products, s3 determinant and numerators, s4
// point numerators, s5 divider chain, s6 squares, s7 output register.
// A non-positive determinant gives valid_res low and every other field zero.
// Reset clears the valid bits of every stage; data registers are not reset, and
// no result is strobed until items arrive after reset.
module triangle_closest_point_to_origin_top
	import tcp_pkg::*;
#(
	parameter int COORD_BITS = 12,
	parameter int FRAC_EXTRA = 8
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	output logic                                       busy,
	input  logic signed [COORD_BITS-1:0]               a_x,
	input  logic signed [COORD_BITS-1:0]               a_y,
	input  logic signed [COORD_BITS-1:0]               a_z,
	input  logic signed [COORD_BITS-1:0]               b_x,
	input  logic signed [COORD_BITS-1:0]               b_y,
	input  logic signed [COORD_BITS-1:0]               b_z,
	input  logic signed [COORD_BITS-1:0]               c_x,
	input  logic signed [COORD_BITS-1:0]               c_y,
	input  logic signed [COORD_BITS-1:0]               c_z,
	output logic                                       done,
	output logic                                       valid_res,
	output logic signed [COORD_BITS+FRAC_EXTRA:0]      near_x,
	output logic signed [COORD_BITS+FRAC_EXTRA:0]      near_y,
	output logic signed [COORD_BITS+FRAC_EXTRA:0]      near_z,
	output logic [2*(COORD_BITS+FRAC_EXTRA)-1:0]       dist_sq,
	output logic                                       inside_res
);

	localparam int C    = COORD_BITS;
	localparam int VW   = C + 1;                 // edge vector
	localparam int DOTW = 2 * C + 4;             // dot products
	localparam int LW   = 4 * C + 9;             // determinant and numerators
	localparam int NW   = 5 * C + 12;            // point numerators, signed
	localparam int MW   = NW + FRAC_EXTRA;       // scaled magnitude (dividend)
	localparam int QB   = C + FRAC_EXTRA;        // quotient bits, |p| < 2^C
	localparam int NB   = QB + 1;                // near field
	localparam int DB   = 2 * QB;                // dist_sq field
	localparam int SUMW = 2 * NB + 2;            // sum of three squares

	// The pipeline never refuses a transfer.
	assign busy = 1'b0;

	logic signed [C-1:0] ain [3];
	logic signed [C-1:0] bin [3];
	logic signed [C-1:0] cin [3];

	assign ain[0] = a_x;
	assign ain[1] = a_y;
	assign ain[2] = a_z;
	assign bin[0] = b_x;
	assign bin[1] = b_y;
	assign bin[2] = b_z;
	assign cin[0] = c_x;
	assign cin[1] = c_y;
	assign cin[2] = c_z;

	// ---------------- s1: vertex a and edge vectors
	logic                 vld_s1;
	logic signed [C-1:0]  a_s1  [3];
	logic signed [VW-1:0] v1_s1 [3];
	logic signed [VW-1:0] v2_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a_s1[i]  <= ain[i];
			v1_s1[i] <= VW'(bin[i]) - VW'(ain[i]);
			v2_s1[i] <= VW'(cin[i]) - VW'(ain[i]);
		end
	end

	// ---------------- s2: dot products
	logic                   vld_s2;
	logic signed [C-1:0]    a_s2  [3];
	logic signed [VW-1:0]   v1_s2 [3];
	logic signed [VW-1:0]   v2_s2 [3];
	logic signed [DOTW-1:0] d11_s2, d12_s2, d22_s2, e1_s2, e2_s2;
	logic signed [DOTW-1:0] d11, d12, d22, e1, e2;

	always_comb begin
		d11 = '0;
		d12 = '0;
		d22 = '0;
		e1  = '0;
		e2  = '0;
		for (int i = 0; i < 3; i++) begin
			d11 = d11 + DOTW'(v1_s1[i]) * DOTW'(v1_s1[i]);
			d12 = d12 + DOTW'(v1_s1[i]) * DOTW'(v2_s1[i]);
			d22 = d22 + DOTW'(v2_s1[i]) * DOTW'(v2_s1[i]);
			e1  = e1  + DOTW'(a_s1[i])  * DOTW'(v1_s1[i]);
			e2  = e2  + DOTW'(a_s1[i])  * DOTW'(v2_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s2   <= a_s1;
		v1_s2  <= v1_s1;
		v2_s2  <= v2_s1;
		d11_s2 <= d11;
		d12_s2 <= d12;
		d22_s2 <= d22;
		e1_s2  <= e1;
		e2_s2  <= e2;
	end

	// ---------------- s3: determinant and barycentric numerators
	logic                 vld_s3;
	logic signed [C-1:0]  a_s3  [3];
	logic signed [VW-1:0] v1_s3 [3];
	logic signed [VW-1:0] v2_s3 [3];
	logic signed [LW-1:0] det_s3, lam1_s3, lam2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s3    <= a_s2;
		v1_s3   <= v1_s2;
		v2_s3   <= v2_s2;
		det_s3  <= LW'(d11_s2) * LW'(d22_s2) - LW'(d12_s2) * LW'(d12_s2);
		lam1_s3 <= LW'(e2_s2) * LW'(d12_s2) - LW'(e1_s2) * LW'(d22_s2);
		lam2_s3 <= LW'(e1_s2) * LW'(d12_s2) - LW'(e2_s2) * LW'(d11_s2);
	end

	// ---------------- s4: point numerators det*a + lam1*v1 + lam2*v2, flags
	tcp_flags_t           flg_s4;
	logic signed [NW-1:0] num_s4 [3];
	logic signed [LW-1:0] det_s4;
	logic signed [LW:0]   slack;
	logic                 det_pos, in_tri;

	always_comb begin
		slack   = (LW+1)'(det_s3) - (LW+1)'(lam1_s3) - (LW+1)'(lam2_s3);
		det_pos = !det_s3[LW-1] && (det_s3 != '0);
		in_tri  = !lam1_s3[LW-1] && !lam2_s3[LW-1] && !slack[LW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_s4 <= '0;
		end else begin
			flg_s4.vld      <= vld_s3;
			flg_s4.ok       <= det_pos;
			flg_s4.enclosed <= in_tri;
			flg_s4.neg      <= '0;
		end
	end

	always_ff @(posedge clk) begin
		det_s4 <= det_s3;
		for (int i = 0; i < 3; i++) begin
			num_s4[i] <= NW'(a_s3[i]) * NW'(det_s3)
				+ NW'(lam1_s3) * NW'(v1_s3[i])
				+ NW'(lam2_s3) * NW'(v2_s3[i]);
		end
	end

	// ---------------- s5: restoring divider, one quotient bit per stage
	logic [MW-1:0] dv_rem_in [3];
	logic [2:0]    dv_neg_in;
	logic [NW-1:0] mag       [3];

	// Divide magnitudes; apply the sign after the quotient so it truncates toward zero.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_neg_in[i] = num_s4[i][NW-1];
			mag[i]       = dv_neg_in[i] ? NW'(-num_s4[i]) : NW'(num_s4[i]);
			dv_rem_in[i] = MW'(mag[i]) << FRAC_EXTRA;
		end
	end

	tcp_flags_t    dv_flg_s5 [QB];
	logic [LW-1:0] dv_det_s5 [QB];
	logic [MW-1:0] dv_rem_s5 [QB][3];
	logic [QB-1:0] dv_quo_s5 [QB][3];

	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int SH = QB - 1 - k;
		logic [MW-1:0] rem_src [3];
		logic [QB-1:0] quo_src [3];
		logic [LW-1:0] det_src;
		tcp_flags_t    flg_src;
		logic [MW-1:0] dsh;

		if (k == 0) begin : g_first
			always_comb begin
				for (int j = 0; j < 3; j++) begin
					rem_src[j] = dv_rem_in[j];
					quo_src[j] = '0;
				end
				det_src     = det_s4;
				flg_src     = flg_s4;
				flg_src.neg = dv_neg_in;
			end
		end else begin : g_next
			always_comb begin
				for (int j = 0; j < 3; j++) begin
					rem_src[j] = dv_rem_s5[k-1][j];
					quo_src[j] = dv_quo_s5[k-1][j];
				end
				det_src = dv_det_s5[k-1];
				flg_src = dv_flg_s5[k-1];
			end
		end

		assign dsh = MW'(det_src) << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_flg_s5[k] <= '0;
			end else begin
				dv_flg_s5[k] <= flg_src;
			end
		end

		// Subtract the shifted divisor where it fits and set this quotient bit.
		always_ff @(posedge clk) begin
			dv_det_s5[k] <= det_src;
			for (int j = 0; j < 3; j++) begin
				if (rem_src[j] >= dsh) begin
					dv_rem_s5[k][j] <= rem_src[j] - dsh;
					dv_quo_s5[k][j] <= quo_src[j] | (QB'(1) << SH);
				end else begin
					dv_rem_s5[k][j] <= rem_src[j];
					dv_quo_s5[k][j] <= quo_src[j];
				end
			end
		end
	end

	// ---------------- s6: signed near values and their squares
	tcp_flags_t           flg_s6;
	logic signed [NB-1:0] near_s6 [3];
	logic [2*NB-1:0]      sq_s6   [3];
	logic signed [NB-1:0] near_v  [3];
	logic signed [2*NB-1:0] sq_v  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			near_v[i] = dv_flg_s5[QB-1].neg[i] ? -NB'(dv_quo_s5[QB-1][i])
				: NB'(dv_quo_s5[QB-1][i]);
			sq_v[i]   = (2*NB)'(near_v[i]) * (2*NB)'(near_v[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flg_s6 <= '0;
		end else begin
			flg_s6 <= dv_flg_s5[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			near_s6[i] <= near_v[i];
			sq_s6[i]   <= sq_v[i];
		end
	end

	// ---------------- s7: sum, saturate, zero a degenerate triangle
	logic [SUMW-1:0]       sum_sq;
	logic [DB-1:0]         dist_v;
	logic                  done_s7, ok_s7, inside_s7;
	logic signed [NB-1:0]  near_s7 [3];
	logic [DB-1:0]         dist_s7;

	always_comb begin
		sum_sq = SUMW'(sq_s6[0]) + SUMW'(sq_s6[1]) + SUMW'(sq_s6[2]);
		dist_v = (sum_sq[SUMW-1:DB] != '0) ? {DB{1'b1}} : sum_sq[DB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s7 <= 1'b0;
		end else begin
			done_s7 <= flg_s6.vld;
		end
	end

	always_ff @(posedge clk) begin
		ok_s7     <= flg_s6.ok;
		inside_s7 <= flg_s6.ok && flg_s6.enclosed;
		dist_s7   <= flg_s6.ok ? dist_v : '0;
		for (int i = 0; i < 3; i++) begin
			near_s7[i] <= flg_s6.ok ? near_s6[i] : '0;
		end
	end

	assign done       = done_s7;
	assign valid_res  = ok_s7;
	assign inside_res = inside_s7;
	assign near_x     = near_s7[0];
	assign near_y     = near_s7[1];
	assign near_z     = near_s7[2];
	assign dist_sq    = dist_s7;

	// ---------------- checks
	a_inside_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && inside_res |-> valid_res)
		else $error("inside flag set on a degenerate triangle");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !valid_res |-> (near_x == '0 && near_y == '0 && near_z == '0
			&& dist_sq == '0))
		else $error("degenerate triangle gave nonzero fields");

	a_strobe_follows: assert property (@(posedge clk) disable iff (!arst_n)
		flg_s6.vld |=> done)
		else $error("result dropped at the output stage");

	a_div_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_flg_s5[QB-1].vld && dv_flg_s5[QB-1].ok |->
			(dv_rem_s5[QB-1][0] < MW'(dv_det_s5[QB-1])))
		else $error("divider remainder not below divisor");

endmodule

>>> tb/triangle_closest_point_to_origin_top_test.sv
module triangle_closest_point_to_origin_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS = 12;
	localparam int FRAC_EXTRA = 8;
	localparam int NEAR_W = COORD_BITS + FRAC_EXTRA + 1;
	localparam int DIST_W = 2 * (COORD_BITS + FRAC_EXTRA);
	localparam int LATENCY = 6 + COORD_BITS + FRAC_EXTRA;
	localparam int N_RANDOM = 1400;

	typedef logic signed [127:0] wide_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef coord_t tri_t [9];

	// one expected result of a triangle
	typedef struct {
		logic              valid_res;
		logic [NEAR_W-1:0] near_x;
		logic [NEAR_W-1:0] near_y;
		logic [NEAR_W-1:0] near_z;
		logic [DIST_W-1:0] dist_sq;
		logic              inside_res;
	} point_t;

	// Scoreboard: predicts the closest point of each accepted triangle and
	// checks results in order against the oldest pending prediction.
	class closest_point_board;
		point_t pending_points[$];
		int     errors;
		int     checked;
		int     valid_seen;
		int     inside_seen;

		function point_t closest_point(tri_t t);
			point_t p;
			longint av[3], v1[3], v2[3];
			longint d11, d12, d22, e1, e2;
			wide_t  det, lam1, lam2, num, q, sq;
			wide_t  lim_hi, lim_lo, dmax;
			lim_hi = (wide_t'(1) <<< (NEAR_W - 1)) - 1;
			lim_lo = -(wide_t'(1) <<< (NEAR_W - 1));
			dmax = (wide_t'(1) <<< DIST_W) - 1;
			d11 = 0; d12 = 0; d22 = 0; e1 = 0; e2 = 0;
			for (int i = 0; i < 3; i++) begin
				av[i] = t[i];
				v1[i] = longint'(t[3+i]) - av[i];
				v2[i] = longint'(t[6+i]) - av[i];
			end
			for (int i = 0; i < 3; i++) begin
				d11 += v1[i] * v1[i];
				d12 += v1[i] * v2[i];
				d22 += v2[i] * v2[i];
				e1  += av[i] * v1[i];
				e2  += av[i] * v2[i];
			end
			det  = wide_t'(d11) * wide_t'(d22) - wide_t'(d12) * wide_t'(d12);
			lam1 = wide_t'(e2) * wide_t'(d12) - wide_t'(e1) * wide_t'(d22);
			lam2 = wide_t'(e1) * wide_t'(d12) - wide_t'(e2) * wide_t'(d11);
			p = '{default: '0};
			if (det <= 0)
				return p;
			sq = 0;
			for (int i = 0; i < 3; i++) begin
				num = wide_t'(av[i]) * det + lam1 * wide_t'(v1[i]) + lam2 * wide_t'(v2[i]);
				// signed division truncates toward zero
				q = (num * 256) / det;
				if (q > lim_hi) q = lim_hi;
				if (q < lim_lo) q = lim_lo;
				sq += q * q;
				case (i)
					0: p.near_x = q[NEAR_W-1:0];
					1: p.near_y = q[NEAR_W-1:0];
					default: p.near_z = q[NEAR_W-1:0];
				endcase
			end
			if (sq > dmax) sq = dmax;
			p.valid_res = 1'b1;
			p.dist_sq = sq[DIST_W-1:0];
			p.inside_res = (lam1 >= 0) && (lam2 >= 0) && (det - (lam1 + lam2) >= 0);
			return p;
		endfunction

		function void note_triangle(tri_t t);
			pending_points.insert(pending_points.size(), closest_point(t));
		endfunction

		function void check_point(point_t got);
			point_t exp;
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected result, nothing pending", $time);
				errors++;
				return;
			end
			exp = pending_points.pop_front();
			checked++;
			if (got.valid_res) valid_seen++;
			if (got.inside_res) inside_seen++;
			if (got.valid_res !== exp.valid_res) begin
				$display("%0t: valid_res exp %0b got %0b", $time, exp.valid_res, got.valid_res);
				errors++;
			end
			if (got.near_x !== exp.near_x) begin
				$display("%0t: near_x exp %0d got %0d", $time,
					$signed(exp.near_x), $signed(got.near_x));
				errors++;
			end
			if (got.near_y !== exp.near_y) begin
				$display("%0t: near_y exp %0d got %0d", $time,
					$signed(exp.near_y), $signed(got.near_y));
				errors++;
			end
			if (got.near_z !== exp.near_z) begin
				$display("%0t: near_z exp %0d got %0d", $time,
					$signed(exp.near_z), $signed(got.near_z));
				errors++;
			end
			if (got.dist_sq !== exp.dist_sq) begin
				$display("%0t: dist_sq exp %0d got %0d", $time, exp.dist_sq, got.dist_sq);
				errors++;
			end
			if (got.inside_res !== exp.inside_res) begin
				$display("%0t: inside_res exp %0b got %0b", $time,
					exp.inside_res, got.inside_res);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	coord_t a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
	logic done;
	logic valid_res;
	logic signed [NEAR_W-1:0] near_x, near_y, near_z;
	logic [DIST_W-1:0] dist_sq;
	logic inside_res;

	closest_point_board board;
	int sent;

	triangle_closest_point_to_origin_top #(
		.COORD_BITS(COORD_BITS),
		.FRAC_EXTRA(FRAC_EXTRA)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.done(done),
		.valid_res(valid_res),
		.near_x(near_x), .near_y(near_y), .near_z(near_z),
		.dist_sq(dist_sq),
		.inside_res(inside_res)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Monitor: sample both channels at the edge. Every input changes by
	// nonblocking assignment, so this sees the values from before the edge.
	always @(posedge clk) begin
		point_t got;
		if (arst_n) begin
			if (start && !busy)
				board.note_triangle('{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z});
			if (done) begin
				got.valid_res  = valid_res;
				got.near_x     = near_x;
				got.near_y     = near_y;
				got.near_z     = near_z;
				got.dist_sq    = dist_sq;
				got.inside_res = inside_res;
				board.check_point(got);
			end
		end
	end

	// Present one triangle and hold it until a transfer happens. Returns right
	// after the accepting edge, so the next item may follow back to back.
	task automatic send_triangle(tri_t t);
		a_x <= t[0]; a_y <= t[1]; a_z <= t[2];
		b_x <= t[3]; b_y <= t[4]; b_z <= t[5];
		c_x <= t[6]; c_y <= t[7]; c_z <= t[8];
		start <= 1'b1;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	// Drop start and leave the input idle.
	task automatic idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic coord_t rand_coord(int span);
		return coord_t'($urandom_range(0, 2 * span) - span);
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(0, 3))
			0: return coord_t'(-2048);
			1: return coord_t'(2047);
			2: return coord_t'(0);
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Build a random triangle: mostly full range, some small, some corner
	// values and some with the third vertex built from the first two (at least half collinear).
	function automatic tri_t random_triangle();
		tri_t t;
		int   kind;
		int   k;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			foreach (t[i]) t[i] = coord_t'($urandom);
		end else if (kind < 75) begin
			foreach (t[i]) t[i] = rand_coord(16);
		end else if (kind < 90) begin
			foreach (t[i]) t[i] = pick_extreme();
		end else begin
			for (int i = 0; i < 3; i++) begin
				t[i] = rand_coord(1000);
				t[3+i] = t[i] + rand_coord(100);
			end
			k = $urandom_range(0, 6) - 3;
			for (int i = 0; i < 3; i++) begin
				if ($urandom_range(0, 1))
					t[6+i] = t[i] + coord_t'(k) * (t[3+i] - t[i]);
				else
					t[6+i] = t[i];
			end
			// make the third vertex collinear in every coordinate, or keep the mixed choice
			if ($urandom_range(0, 1))
				for (int i = 0; i < 3; i++) t[6+i] = t[i] + coord_t'(k) * (t[3+i] - t[i]);
		end
		return t;
	endfunction

	initial begin
		tri_t directed [$];
		int   wait_cycles;
		board = new();
		sent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// degenerate: all zero, all one corner, repeated and collinear vertices
		directed.insert(directed.size(), '{0, 0, 0, 0, 0, 0, 0, 0, 0});
		directed.insert(directed.size(), '{2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047});
		directed.insert(directed.size(),
			'{-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048});
		directed.insert(directed.size(), '{5, 6, 7, 5, 6, 7, 100, -3, 9});
		directed.insert(directed.size(), '{5, 6, 7, 100, -3, 9, 5, 6, 7});
		directed.insert(directed.size(), '{1, 2, 3, 2, 4, 6, 3, 6, 9});
		directed.insert(directed.size(), '{-2048, -2048, -2048, 0, 0, 0, 2047, 2047, 2047});
		// origin projects inside, and well outside
		directed.insert(directed.size(), '{-1000, -1000, 5, 1000, -1000, 5, 0, 1000, 5});
		directed.insert(directed.size(), '{100, 100, 100, 200, 100, 100, 100, 200, 100});
		directed.insert(directed.size(), '{100, 100, 100, 100, 200, 100, 200, 100, 100});
		// extreme coordinates on every field, then unit-size triangles
		directed.insert(directed.size(),
			'{-2048, -2048, -2048, 2047, -2048, 2047, -2048, 2047, 2047});
		directed.insert(directed.size(), '{2047, -2048, 0, -2048, 2047, 0, 0, 0, 2047});
		directed.insert(directed.size(), '{-2048, 0, 0, 0, -2048, 0, 0, 0, -2048});
		directed.insert(directed.size(), '{2047, 0, 0, 0, 2047, 0, 0, 0, 2047});
		directed.insert(directed.size(),
			'{2047, 2047, -2048, 2047, -2048, 2047, -2048, 2047, 2047});
		directed.insert(directed.size(), '{1, 0, 0, 0, 1, 0, 0, 0, 1});
		directed.insert(directed.size(), '{-1, -1, -1, 1, -1, -1, -1, 1, -1});
		foreach (directed[i]) send_triangle(directed[i]);

		for (int n = 0; n < N_RANDOM; n++) begin
			// hold off until the pipeline drains once, midway
			if (n == N_RANDOM / 2) begin
				start <= 1'b0;
				@(posedge clk);
				while (board.pending_points.size() != 0) @(posedge clk);
			end
			// idle about a quarter of the cycles, except for a long stretch with no gaps
			if (n < 500 || n > 800)
				while ($urandom_range(0, 99) < 24) idle_cycles(1);
			send_triangle(random_triangle());
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (board.pending_points.size() != 0 && wait_cycles < 10 * LATENCY) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 8) @(posedge clk);

		$display("Sent %0d triangles, checked %0d results (%0d valid, %0d inside).",
			sent, board.checked, board.valid_seen, board.inside_seen);
		$display("Covered degenerate, corner, small and full range vertex sets.");
		if (board.errors == 0 && board.pending_points.size() == 0) begin
			$display("triangle_closest_point_to_origin_top_test passed");
		end else begin
			if (board.pending_points.size() != 0)
				$display("%0t: %0d results never arrived", $time,
					board.pending_points.size());
			$display("triangle_closest_point_to_origin_top_test failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("%0t: timeout", $time);
		$display("triangle_closest_point_to_origin_top_test failed");
		$finish;
	end

endmodule
